// ===== hdl/patch_border_vertex_dedup_core_macros.svh =====
// Assertion macros shared by the checker.
`ifndef PATCH_BORDER_VERTEX_DEDUP_CORE_MACROS_SVH
`define PATCH_BORDER_VERTEX_DEDUP_CORE_MACROS_SVH

`define PBVD_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`define PBVD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/pbvd_pkg.sv =====
package pbvd_pkg;

    localparam int IDX_W   = 12;
    localparam int COORD_W = 64;
    localparam int GRID_W  = 11;
    localparam int POS_W   = 10;

    localparam logic       KIND_VERTEX = 1'b0;
    localparam logic       KIND_CORNER = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_UNSET    = 2'd2;

    localparam logic       REG_COLUMNS = 1'b0;
    localparam logic       REG_ROWS    = 1'b1;

    typedef struct packed {
        logic                   kind;
        logic                   border;
        logic [COORD_W-1:0]     x;
        logic [COORD_W-1:0]     y;
        logic [COORD_W-1:0]     z;
        logic [IDX_W-1:0]       corner;
    } cmd_t;

    typedef struct packed {
        logic [IDX_W-1:0]       new_index;
        logic                   is_duplicate;
        logic [1:0]             status;
    } res_t;

    function automatic logic [POS_W-1:0] last_pos(input logic [GRID_W-1:0] v);
        logic [GRID_W-1:0] c;
        c = v;
        if (v < GRID_W'(2)) c = GRID_W'(2);
        if (v > GRID_W'(1024)) c = GRID_W'(1024);
        return POS_W'(c - GRID_W'(1));
    endfunction

endpackage

// ===== hdl/pbvd_ram.sv =====
module pbvd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hdl/pbvd_front.sv =====
module pbvd_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [pbvd_pkg::GRID_W-1:0]   cfg_index,
    input  logic [pbvd_pkg::GRID_W-1:0]   cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_kind,
    input  logic [pbvd_pkg::COORD_W-1:0]  in_x,
    input  logic [pbvd_pkg::COORD_W-1:0]  in_y,
    input  logic [pbvd_pkg::COORD_W-1:0]  in_z,
    input  logic [pbvd_pkg::IDX_W-1:0]    in_corner,
    input  logic                          vtx_full,
    output logic                          q_valid,
    input  logic                          q_ready,
    output pbvd_pkg::cmd_t                q_cmd
);
    import pbvd_pkg::*;

    logic [GRID_W-1:0] cols_reg, rows_reg;
    logic [POS_W-1:0]  col_reg, row_reg, col_next, row_next;
    logic [POS_W-1:0]  last_col, last_row;
    logic              q_valid_reg;
    cmd_t              q_cmd_reg;
    logic              take, adv, border;

    assign last_col = last_pos(cols_reg);
    assign last_row = last_pos(rows_reg);
    assign border   = (col_reg == '0) || (col_reg >= last_col) ||
                      (row_reg == '0) || (row_reg >= last_row);
    assign in_ready = !q_valid_reg || q_ready;
    assign take     = in_valid && in_ready;
    assign adv      = take && in_kind == KIND_VERTEX && !vtx_full;

    always_comb begin
        row_next = row_reg + POS_W'(1);
        col_next = col_reg;
        if (row_reg >= last_row) begin
            row_next = '0;
            col_next = (col_reg >= last_col) ? '0 : col_reg + POS_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg    <= GRID_W'(3);
            rows_reg    <= GRID_W'(3);
            col_reg     <= '0;
            row_reg     <= '0;
            q_valid_reg <= 1'b0;
        end else begin
            if (cfg_we && cfg_index == GRID_W'(REG_COLUMNS)) cols_reg <= cfg_data;
            if (cfg_we && cfg_index == GRID_W'(REG_ROWS)) rows_reg <= cfg_data;
            if (adv) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (in_ready) q_valid_reg <= in_valid;
        end
        if (take) begin
            q_cmd_reg <= '{kind: in_kind, border: border, x: in_x, y: in_y,
                           z: in_z, corner: in_corner};
        end
    end

    assign q_valid = q_valid_reg;
    assign q_cmd   = q_cmd_reg;
endmodule

// ===== hdl/pbvd_back.sv =====
module pbvd_back #(
    parameter int MAX_VERTICES = 4096,
    parameter int MAX_BORDER   = 1024
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    output logic             q_ready,
    input  pbvd_pkg::cmd_t   q_cmd,
    output logic             vtx_full,
    output logic             out_valid,
    input  logic             out_ready,
    output pbvd_pkg::res_t   out_res
);
    import pbvd_pkg::*;

    localparam int VA_W  = $clog2(MAX_VERTICES);
    localparam int BA_W  = $clog2(MAX_BORDER);
    localparam int VC_W  = VA_W + 1;
    localparam int BC_W  = BA_W + 1;
    localparam int BE_W  = 3 * COORD_W + IDX_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]       state_reg;
    logic [VC_W-1:0]  vcnt_reg;
    logic [IDX_W:0]   ucnt_reg;
    logic [BC_W-1:0]  bcnt_reg;
    logic [BC_W-1:0]  k_reg;
    cmd_t             cmd_reg;
    res_t             res_reg;
    res_t             out_res_reg;
    logic             out_valid_reg;
    logic             out_load;

    logic             bwe, rwe;
    logic [BE_W-1:0]  bwdata, brdata;
    logic [IDX_W-1:0] rdata, rwdata;
    logic [VA_W-1:0]  rraddr;
    logic             corner_ok;

    pbvd_ram #(.WIDTH(BE_W), .DEPTH(MAX_BORDER)) u_border (
        .aclk(aclk), .we(bwe), .waddr(bcnt_reg[BA_W-1:0]), .wdata(bwdata),
        .raddr(k_reg[BA_W-1:0]), .rdata(brdata)
    );
    pbvd_ram #(.WIDTH(IDX_W), .DEPTH(MAX_VERTICES)) u_remap (
        .aclk(aclk), .we(rwe), .waddr(vcnt_reg[VA_W-1:0]), .wdata(rwdata),
        .raddr(rraddr), .rdata(rdata)
    );

    assign vtx_full  = vcnt_reg == VC_W'(MAX_VERTICES);
    assign q_ready   = state_reg == S_IDLE;
    assign rraddr    = VA_W'(cmd_reg.corner);
    assign corner_ok = VC_W'(cmd_reg.corner) < vcnt_reg &&
                       32'(cmd_reg.corner) < MAX_VERTICES;
    assign out_load  = state_reg == S_OUT && (!out_valid_reg || out_ready);

    always_comb begin
        bwe    = 1'b0;
        rwe    = 1'b0;
        rwdata = ucnt_reg[IDX_W-1:0];
        bwdata = {cmd_reg.x, cmd_reg.y, cmd_reg.z, ucnt_reg[IDX_W-1:0]};
        if (state_reg == S_SCAN && k_reg == bcnt_reg) begin
            rwe = 1'b1;
            bwe = cmd_reg.border && bcnt_reg != BC_W'(MAX_BORDER);
        end
        if (state_reg == S_CMP &&
            brdata[BE_W-1:IDX_W] == {cmd_reg.x, cmd_reg.y, cmd_reg.z}) begin
            rwe    = 1'b1;
            rwdata = brdata[IDX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            vcnt_reg      <= '0;
            ucnt_reg      <= '0;
            bcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                out_valid_reg <= 1'b1;
                out_res_reg   <= res_reg;
            end else if (out_valid_reg && out_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        cmd_reg   <= q_cmd;
                        k_reg     <= '0;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (cmd_reg.kind == KIND_CORNER) begin
                        if (corner_ok) begin
                            state_reg <= S_READ;
                        end else begin
                            res_reg   <= '{new_index: '0, is_duplicate: 1'b0,
                                           status: ST_UNSET};
                            state_reg <= S_OUT;
                        end
                    end else if (vtx_full) begin
                        res_reg   <= '{new_index: '0, is_duplicate: 1'b0,
                                       status: ST_FULL};
                        state_reg <= S_OUT;
                    end else begin
                        if (!cmd_reg.border) k_reg <= bcnt_reg;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (k_reg == bcnt_reg) begin
                        res_reg <= '{new_index: ucnt_reg[IDX_W-1:0], is_duplicate: 1'b0,
                                     status: (cmd_reg.border &&
                                              bcnt_reg == BC_W'(MAX_BORDER))
                                             ? ST_FULL : ST_OK};
                        ucnt_reg <= ucnt_reg + (IDX_W+1)'(1);
                        vcnt_reg <= vcnt_reg + VC_W'(1);
                        if (bwe) bcnt_reg <= bcnt_reg + BC_W'(1);
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (rwe) begin
                        res_reg  <= '{new_index: brdata[IDX_W-1:0], is_duplicate: 1'b1,
                                      status: ST_OK};
                        vcnt_reg <= vcnt_reg + VC_W'(1);
                        state_reg <= S_OUT;
                    end else begin
                        k_reg     <= k_reg + BC_W'(1);
                        state_reg <= S_SCAN;
                    end
                end
                S_READ: begin
                    res_reg   <= '{new_index: rdata, is_duplicate: 1'b0, status: ST_OK};
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
endmodule

// ===== hdl/patch_border_vertex_dedup_core.sv =====
// Channel   | Direction | tdata (low to high)               | tuser
// s_axis    | in        | x_bits, y_bits, z_bits, corner_index | kind
// m_axis    | out       | new_index, is_duplicate, status   | -
// Each accepted word passes the front register and the back states IDLE and
// CHECK; a full-table reject or unwritten corner then goes to OUT, an interior
// vertex via SCAN, a written corner via READ, and a border vertex via SCAN/CMP
// pairs up to a hit, as each compare waits on the registered border memory read.
// The front register takes the next word while the back is busy; a second
// result waits in the back until m_tready frees the output register.
// aresetn is synchronous, active low; the memories need no clearing.
module patch_border_vertex_dedup_core #(
    parameter int MAX_VERTICES = 4096,
    parameter int MAX_BORDER   = 1024
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [10:0]  cfg_index,
    input  logic [10:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [207:0] s_tdata,   // x_bits, y_bits, z_bits, corner_index, pad
    input  logic         s_tuser,   // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata    // new_index, is_duplicate, status, pad
);
    import pbvd_pkg::*;

    logic   q_valid, q_ready, vtx_full;
    cmd_t   q_cmd;
    res_t   res;

    pbvd_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_kind(s_tuser),
        .in_x(s_tdata[63:0]), .in_y(s_tdata[127:64]), .in_z(s_tdata[191:128]),
        .in_corner(s_tdata[203:192]), .vtx_full(vtx_full),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    pbvd_back #(.MAX_VERTICES(MAX_VERTICES), .MAX_BORDER(MAX_BORDER)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd), .vtx_full(vtx_full),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
    );

    assign m_tdata = {1'b0, res.status, res.is_duplicate, res.new_index};
endmodule

// ===== hdl/pbvd_checker.sv =====
module pbvd_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [15:0]  m_tdata
);
    `include "patch_border_vertex_dedup_core_macros.svh"

    `PBVD_ASSERT_NEXT(a_in_hold, aclk, aresetn, s_tvalid && !s_tready, s_tvalid && $stable(s_tuser), "input word dropped")
    `PBVD_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word dropped")
    `PBVD_ASSERT_IMPL(a_status_code, aclk, aresetn, m_tvalid, m_tdata[14:13] != 2'd3, "bad status")
    `PBVD_ASSERT_IMPL(a_dup_ok, aclk, aresetn, m_tvalid && m_tdata[12], m_tdata[14:13] == 2'd0, "duplicate with error")
    `PBVD_ASSERT_IMPL(a_err_zero, aclk, aresetn, m_tvalid && m_tdata[14:13] == 2'd2, m_tdata[11:0] == 12'd0, "unset corner with index")
endmodule

bind patch_border_vertex_dedup_core pbvd_checker u_pbvd_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// ===== test/patch_border_vertex_dedup_core_test.sv =====
`timescale 1ns / 100ps

module patch_border_vertex_dedup_core_test;
    import pbvd_pkg::*;

    typedef struct {
        logic               kind;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [IDX_W-1:0]   corner;
    } vertex_word_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_we = 1'b0;
    logic [10:0]  cfg_index = '0;
    logic [10:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [207:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [15:0]  m_tdata;

    patch_border_vertex_dedup_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #2 aclk = ~aclk;

    // dedup predictor state
    int unsigned        cols_setting = 3, rows_setting = 3;
    int unsigned        vtx_count = 0, uniq_count = 0, col_at = 0, row_at = 0, brd_count = 0;
    logic [IDX_W-1:0]   remap_copy [4096];
    logic [COORD_W-1:0] brd_x [1024];
    logic [COORD_W-1:0] brd_y [1024];
    logic [COORD_W-1:0] brd_z [1024];
    logic [IDX_W-1:0]   brd_idx [1024];

    vertex_word_t pending_words [$];
    res_t         index_expected [$];
    int unsigned  errors = 0, n_words = 0, n_results = 0, n_dups = 0, n_full = 0, n_unset = 0;
    int unsigned  gen_vertices = 0;

    function automatic int unsigned grid_last(int unsigned v);
        if (v < 2) return 1;
        if (v > 1024) return 1023;
        return v - 1;
    endfunction

    function automatic res_t predict_index(vertex_word_t w);
        res_t r;
        int unsigned lc, lr, k;
        logic border, found;
        r = '0;
        if (w.kind == KIND_CORNER) begin
            if (w.corner >= vtx_count) r.status = ST_UNSET;
            else r.new_index = remap_copy[w.corner];
            return r;
        end
        if (vtx_count >= 4096) begin
            r.status = ST_FULL;
            return r;
        end
        lc = grid_last(cols_setting);
        lr = grid_last(rows_setting);
        border = (col_at == 0) || (col_at >= lc) || (row_at == 0) || (row_at >= lr);
        found = 1'b0;
        if (border) begin
            for (k = 0; k < brd_count; k++) begin
                if (!found && brd_x[k] == w.x && brd_y[k] == w.y && brd_z[k] == w.z) begin
                    found = 1'b1;
                    r.new_index = brd_idx[k];
                end
            end
        end
        if (found) begin
            r.is_duplicate = 1'b1;
        end else begin
            r.new_index = IDX_W'(uniq_count);
            uniq_count++;
            if (border) begin
                if (brd_count < 1024) begin
                    brd_x[brd_count] = w.x;
                    brd_y[brd_count] = w.y;
                    brd_z[brd_count] = w.z;
                    brd_idx[brd_count] = r.new_index;
                    brd_count++;
                end else begin
                    r.status = ST_FULL;
                end
            end
        end
        remap_copy[vtx_count] = r.new_index;
        vtx_count++;
        if (row_at >= lr) begin
            row_at = 0;
            col_at = (col_at >= lc) ? 0 : col_at + 1;
        end else begin
            row_at++;
        end
        return r;
    endfunction

    function automatic int unsigned draw_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // driver
    vertex_word_t cur_word;
    int unsigned  send_gap = 0, send_burst = 0;
    always @(posedge aclk) begin
        res_t r;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && !s_tready)) begin
            if (s_tvalid) begin
                r = predict_index(cur_word);
                index_expected = {index_expected, r};
                n_words++;
            end
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                cur_word = pending_words.pop_front();
                s_tdata <= {4'b0, cur_word.corner, cur_word.z, cur_word.y, cur_word.x};
                s_tuser <= cur_word.kind;
                s_tvalid <= 1'b1;
                if ($urandom_range(0, 299) == 0) send_burst = 200;
                if (send_burst > 0) send_burst--;
                else send_gap = draw_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    int unsigned recv_stall = 0;
    always @(posedge aclk) begin
        res_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.new_index = m_tdata[11:0];
                got.is_duplicate = m_tdata[12];
                got.status = m_tdata[14:13];
                n_results++;
                if (index_expected.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word, actual %h", $time, got);
                end else begin
                    want = index_expected.pop_front();
                    if (got.new_index !== want.new_index) begin
                        errors++;
                        $display("%0t: new_index expected %0d actual %0d",
                                 $time, want.new_index, got.new_index);
                    end
                    if (got.is_duplicate !== want.is_duplicate) begin
                        errors++;
                        $display("%0t: is_duplicate expected %0d actual %0d",
                                 $time, want.is_duplicate, got.is_duplicate);
                    end
                    if (got.status !== want.status) begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                    end
                    if (want.is_duplicate) n_dups++;
                    if (want.status == ST_FULL) n_full++;
                    if (want.status == ST_UNSET) n_unset++;
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 9) < 3) recv_stall = draw_gap();
            end
        end
    end

    task automatic queue_vertex(logic [63:0] x, logic [63:0] y, logic [63:0] z);
        vertex_word_t w;
        w.kind = KIND_VERTEX;
        w.x = x;
        w.y = y;
        w.z = z;
        w.corner = 12'($urandom);
        pending_words = {pending_words, w};
        gen_vertices++;
    endtask

    task automatic queue_corner(logic [11:0] c);
        vertex_word_t w;
        w.kind = KIND_CORNER;
        w.x = {$urandom, $urandom};
        w.y = {$urandom, $urandom};
        w.z = {$urandom, $urandom};
        w.corner = c;
        pending_words = {pending_words, w};
    endtask

    task automatic write_grid(logic [10:0] cols, logic [10:0] rows);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= 11'(REG_COLUMNS);
        cfg_data <= cols;
        @(posedge aclk);
        cfg_index <= 11'(REG_ROWS);
        cfg_data <= rows;
        @(posedge aclk);
        cfg_we <= 1'b0;
        cols_setting = cols;
        rows_setting = rows;
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_words.size() != 0 || s_tvalid || index_expected.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    logic [63:0] coord_pool [12];

    initial begin
        int unsigned i, ph, r;
        logic [10:0] gc, gr;
        coord_pool[0] = 64'h0;
        coord_pool[1] = 64'h8000_0000_0000_0000;
        coord_pool[2] = 64'h7FF8_0000_0000_0001;
        coord_pool[3] = 64'hFFFF_FFFF_FFFF_FFFF;
        for (i = 4; i < 12; i++) coord_pool[i] = rand64();

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset grid, signed zeros, NaN, all ones, corners
        queue_corner(12'd0);
        queue_vertex(64'h0, 64'h0, 64'h0);
        queue_vertex(64'h8000_0000_0000_0000, 64'h0, 64'h0);
        queue_vertex(64'h0, 64'h0, 64'h0);
        queue_vertex(coord_pool[2], coord_pool[2], coord_pool[2]);
        queue_vertex(coord_pool[3], coord_pool[3], coord_pool[3]);
        queue_vertex(coord_pool[2], coord_pool[2], coord_pool[2]);
        queue_vertex(rand64(), rand64(), rand64());
        queue_vertex(coord_pool[3], coord_pool[3], coord_pool[3]);
        queue_corner(12'd4);
        queue_corner(12'd2);
        queue_corner(12'd4095);
        queue_corner(12'd8);
        wait_drained();
        write_grid(11'd0, 11'd2047);
        for (i = 0; i < 5; i++) queue_vertex(coord_pool[i], coord_pool[0], coord_pool[1]);
        wait_drained();
        write_grid(11'd1024, 11'd1);
        for (i = 0; i < 4; i++) queue_vertex(coord_pool[i], coord_pool[0], coord_pool[1]);
        queue_corner(12'd12);
        wait_drained();

        // random phases, new grid between phases
        for (ph = 0; ph < 10; ph++) begin
            r = $urandom_range(0, 9);
            if (r == 0) begin
                gc = 11'($urandom);
                gr = 11'($urandom);
            end else if (r == 1) begin
                gc = 11'($urandom_range(0, 1));
                gr = 11'($urandom_range(1023, 1025));
            end else begin
                gc = 11'($urandom_range(2, 8));
                gr = 11'($urandom_range(2, 8));
            end
            write_grid(gc, gr);
            for (i = 0; i < 103; i++) begin
                if ($urandom_range(0, 3) == 0) begin
                    if ($urandom_range(0, 7) == 0 || gen_vertices == 0) queue_corner(12'($urandom));
                    else queue_corner(12'($urandom_range(0, gen_vertices - 1)));
                end else if ($urandom_range(0, 9) < 8) begin
                    queue_vertex(coord_pool[$urandom_range(0, 11)],
                                 coord_pool[$urandom_range(0, 3)],
                                 coord_pool[$urandom_range(0, 3)]);
                end else begin
                    queue_vertex(rand64(), rand64(), rand64());
                end
            end
            wait_drained();
        end
        repeat (50) @(posedge aclk);

        $display("covered %0d words, %0d results: %0d duplicates, %0d table full, %0d unset",
                 n_words, n_results, n_dups, n_full, n_unset);
        $display("border table filled to %0d, remap table to %0d", brd_count, vtx_count);
        if (errors == 0 && index_expected.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #80_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
